@@ design/hjrd_pkg.sv @@
// ----------------------------------------------------------------------------
// HID joystick report decoder package
// Item types, register indexes and widths for decoder, divider and checker.
// ----------------------------------------------------------------------------
package hjrd_pkg;

   // Fixed field widths
   localparam int OFFSET_W   = 6;   // byte offset inside a report
   localparam int LEN_W      = 7;   // report length and minimum length
   localparam int AXIS_W     = 16;  // widest raw axis value
   localparam int DIVIDEND_W = 24;  // |raw - min| * 255 fits in 24 bits
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_AXIS_SETUP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_AXIS_SETUP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_LOGICAL_RANGE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LOGICAL_RANGE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_OFFSETS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_MASKS      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_REPORT_LENGTH = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_STICK_NUMBER      = 3'd7;

   typedef struct packed {
      logic [7:0] report_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0]        direction_map;
      logic              map_changed;
      logic signed [7:0] analog_x;
      logic signed [7:0] analog_y;
      logic [1:0]        port_index;
   } rsp_item_type;

endpackage

@@ design/hjrd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module hjrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hjrd_div.sv @@
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module hjrd_div import hjrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [AXIS_W-1:0]     divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [AXIS_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [AXIS_W-1:0]     divisor_ff, divisor_in;

   logic [AXIS_W:0]   shifted;
   logic [AXIS_W+1:0] trial;
   logic              take;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor_ff};
   assign take    = ~trial[AXIS_W+1];

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = take ? trial[AXIS_W-1:0] : shifted[AXIS_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], take};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/hid_joystick_report_decode.sv @@
// ----------------------------------------------------------------------------
// HID joystick report decoder
// Collects one joystick report byte by byte and decodes axes and buttons.
// ----------------------------------------------------------------------------
// Usage. Report bytes arrive on the req_ channel, one byte per item, with
// last_byte set on the final byte. While the block is collecting, it takes one
// item in every cycle and writes it into the report RAM; bytes beyond the RAM
// depth are dropped. At the last byte the report length is checked against
// min_report_length. A short report gives no result and the block is at once
// ready for the next report. Otherwise req_stall rises and a decode sequencer
// reads eight bytes from the RAM (axis low and high bytes, four button bytes),
// one read a cycle, then scales each axis with a shared iterative divider.
// The result on rsp_ follows the RAM reads, then per axis a direct value or,
// when division is needed, a run of the 24-step divider, then the item build.
// The result waits in an output register, so the next report may be collected
// while the receiver holds rsp_stall; only a further decode waits for it.
// Configuration must be written on the csr_ port while the block is idle;
// the block itself does not enforce this.
// Reset is synchronous: the sequencer, byte count, previous map and configuration
// registers return to their defaults; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module hid_joystick_report_decode import hjrd_pkg::*; #(
   parameter int MAX_REPORT_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // report byte channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_REPORT_BYTES);
   localparam int CNT_W  = $clog2(MAX_REPORT_BYTES + 1);
   localparam logic [CNT_W-1:0]    CNT_MAX = CNT_W'(MAX_REPORT_BYTES);
   localparam logic [OFFSET_W:0]   DEPTH_LIMIT = (OFFSET_W + 1)'(MAX_REPORT_BYTES);

   // Read slots of the decode sequence, in issue order.
   localparam logic [2:0] SLOT_X_LO = 3'd0;
   localparam logic [2:0] SLOT_X_HI = 3'd1;
   localparam logic [2:0] SLOT_Y_LO = 3'd2;
   localparam logic [2:0] SLOT_Y_HI = 3'd3;
   localparam logic [2:0] SLOT_B1   = 3'd4;
   localparam logic [2:0] SLOT_B2   = 3'd5;
   localparam logic [2:0] SLOT_B3   = 3'd6;
   localparam logic [2:0] SLOT_B4   = 3'd7;
   localparam logic [3:0] READ_DONE = 4'd8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_PREP,
      S_DIV,
      S_EMIT
   } state_type;

   typedef enum logic {
      AXIS_X,
      AXIS_Y
   } axis_type;

   // ------------------------------------------------------------------------
   // Configuration registers. The port takes a write whenever reset is low; the contract is
   // that software writes only while no report is being decoded.
   // ------------------------------------------------------------------------
   logic [6:0]  x_setup_ff, y_setup_ff;
   logic [31:0] x_range_ff, y_range_ff;
   logic [23:0] btn_offsets_ff;
   logic [31:0] btn_masks_ff;
   logic [LEN_W-1:0] min_len_ff;
   logic [1:0]  stick_ff;
   logic        csr_write;

   assign csr_ready = ~reset;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_setup_ff     <= 7'd0;
         y_setup_ff     <= 7'd1;
         x_range_ff     <= 32'h00FF_0000;
         y_range_ff     <= 32'h00FF_0000;
         btn_offsets_ff <= '0;
         btn_masks_ff   <= '0;
         min_len_ff     <= '0;
         stick_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_X_AXIS_SETUP:      x_setup_ff     <= csr_wdata[6:0];
            CSR_Y_AXIS_SETUP:      y_setup_ff     <= csr_wdata[6:0];
            CSR_X_LOGICAL_RANGE:   x_range_ff     <= csr_wdata;
            CSR_Y_LOGICAL_RANGE:   y_range_ff     <= csr_wdata;
            CSR_BUTTON_OFFSETS:    btn_offsets_ff <= csr_wdata[23:0];
            CSR_BUTTON_MASKS:      btn_masks_ff   <= csr_wdata;
            CSR_MIN_REPORT_LENGTH: min_len_ff     <= csr_wdata[LEN_W-1:0];
            CSR_STICK_NUMBER:      stick_ff       <= csr_wdata[1:0];
            default:               ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------------
   state_type          state_ff, state_in;
   axis_type           axis_ff, axis_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [3:0]         rd_cnt_ff, rd_cnt_in;
   logic               cap_valid_ff, cap_valid_in;
   logic [2:0]         cap_slot_ff, cap_slot_in;
   logic               cap_zero_ff, cap_zero_in;
   logic [AXIS_W-1:0]  raw_x_ff, raw_x_in;
   logic [AXIS_W-1:0]  raw_y_ff, raw_y_in;
   logic [3:0]         btn_hit_ff, btn_hit_in;
   logic [7:0]         ax_ff, ax_in;
   logic [7:0]         ay_ff, ay_in;
   logic [7:0]         prev_map_ff, prev_map_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // RAM and divider hook-up
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [7:0]            ram_rd_data;
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [AXIS_W-1:0]     div_divisor;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;

   logic req_take;

   assign req_stall = reset | (state_ff != S_IDLE);
   assign req_take  = req_valid & ~req_stall;

   // Bytes are written at the current count until the store is full.
   assign ram_wr_en   = req_take & (count_ff < CNT_MAX);
   assign ram_wr_addr = count_ff[ADDR_W-1:0];

   hjrd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_REPORT_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_item.report_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hjrd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ------------------------------------------------------------------------
   // Read address of the current slot. An offset at or beyond the store
   // depth, and the high byte of an 8-bit axis, read as zero.
   // ------------------------------------------------------------------------
   logic [OFFSET_W-1:0] slot_off;
   logic                slot_hi;
   logic                slot_wide;
   logic [OFFSET_W:0]   slot_addr;
   logic                slot_zero;

   always_comb begin
      slot_hi   = 1'b0;
      slot_wide = 1'b0;
      case (rd_cnt_ff[2:0])
         SLOT_X_LO: slot_off = x_setup_ff[5:0];
         SLOT_X_HI: begin
            slot_off  = x_setup_ff[5:0];
            slot_hi   = 1'b1;
            slot_wide = x_setup_ff[6];
         end
         SLOT_Y_LO: slot_off = y_setup_ff[5:0];
         SLOT_Y_HI: begin
            slot_off  = y_setup_ff[5:0];
            slot_hi   = 1'b1;
            slot_wide = y_setup_ff[6];
         end
         SLOT_B1:   slot_off = btn_offsets_ff[5:0];
         SLOT_B2:   slot_off = btn_offsets_ff[11:6];
         SLOT_B3:   slot_off = btn_offsets_ff[17:12];
         SLOT_B4:   slot_off = btn_offsets_ff[23:18];
         default:   slot_off = '0;
      endcase
      slot_addr   = {1'b0, slot_off} + {{OFFSET_W{1'b0}}, slot_hi};
      slot_zero   = (slot_addr >= DEPTH_LIMIT) | (slot_hi & ~slot_wide);
      ram_rd_addr = slot_zero ? '0 : slot_addr[ADDR_W-1:0];
   end

   // ------------------------------------------------------------------------
   // Axis scaling set-up for the axis in hand. The sign of the quotient is
   // known before dividing, so the divider only ever sees magnitudes; a
   // negative quotient clamps to zero without running it.
   // ------------------------------------------------------------------------
   logic [AXIS_W-1:0] cur_raw;
   logic [31:0]       cur_range;
   logic [AXIS_W-1:0] lo_val, hi_val;
   logic [AXIS_W:0]   num_diff, den_diff;
   logic [AXIS_W:0]   num_abs, den_abs;
   logic              raw_bypass;
   logic              den_zero;
   logic              quo_nonpos;
   logic [7:0]        raw_clamped;
   logic [7:0]        quo_clamped;

   always_comb begin
      cur_raw     = (axis_ff == AXIS_X) ? raw_x_ff : raw_y_ff;
      cur_range   = (axis_ff == AXIS_X) ? x_range_ff : y_range_ff;
      lo_val      = cur_range[15:0];
      hi_val      = cur_range[31:16];
      raw_bypass  = (lo_val == 16'd0) & (hi_val == 16'd255);
      den_diff    = {1'b0, hi_val} - {1'b0, lo_val};
      num_diff    = {1'b0, cur_raw} - {1'b0, lo_val};
      den_zero    = (den_diff == '0);
      quo_nonpos  = (num_diff == '0) | (num_diff[AXIS_W] ^ den_diff[AXIS_W]);
      num_abs     = num_diff[AXIS_W] ? (~num_diff + 1'b1) : num_diff;
      den_abs     = den_diff[AXIS_W] ? (~den_diff + 1'b1) : den_diff;
      // |num| * 255 as a shift and a subtract
      div_dividend = {num_abs[AXIS_W-1:0], 8'd0} - {8'd0, num_abs[AXIS_W-1:0]};
      div_divisor  = den_abs[AXIS_W-1:0];
      raw_clamped  = (cur_raw[15:8] != 8'd0) ? 8'd255 : cur_raw[7:0];
      quo_clamped  = (div_quotient[DIVIDEND_W-1:8] != '0) ? 8'd255 : div_quotient[7:0];
   end

   // ------------------------------------------------------------------------
   // Result item built from the two scaled axes and the button hits.
   // ------------------------------------------------------------------------
   logic [7:0]   new_map;
   rsp_item_type new_item;

   always_comb begin
      new_map[0]   = ax_ff > 8'd192;
      new_map[1]   = ax_ff < 8'd64;
      new_map[2]   = ay_ff > 8'd192;
      new_map[3]   = ay_ff < 8'd64;
      new_map[7:4] = btn_hit_ff;
      new_item.direction_map = new_map;
      new_item.map_changed   = (new_map != prev_map_ff);
      new_item.analog_x      = $signed(ax_ff ^ 8'h80);
      new_item.analog_y      = $signed(ay_ff ^ 8'h80);
      // stick 0 and 1 trade places, 2 and 3 stay
      new_item.port_index    = {stick_ff[1], stick_ff[1] ? stick_ff[0] : ~stick_ff[0]};
   end

   // ------------------------------------------------------------------------
   // Next-state logic of the sequencer
   // ------------------------------------------------------------------------
   logic [CNT_W-1:0] count_inc;
   logic [7:0]       cap_data;
   logic             axis_store;
   logic [7:0]       axis_value;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      count_in     = count_ff;
      rd_cnt_in    = rd_cnt_ff;
      cap_valid_in = 1'b0;
      cap_slot_in  = cap_slot_ff;
      cap_zero_in  = cap_zero_ff;
      raw_x_in     = raw_x_ff;
      raw_y_in     = raw_y_ff;
      btn_hit_in   = btn_hit_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      prev_map_in  = prev_map_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_item_in  = rsp_item_ff;
      div_start    = 1'b0;
      axis_store   = 1'b0;
      axis_value   = 8'd0;

      count_inc = (count_ff < CNT_MAX) ? count_ff + 1'b1 : count_ff;

      // Capture of the byte read in the previous cycle.
      cap_data = cap_zero_ff ? 8'd0 : ram_rd_data;
      if (cap_valid_ff) begin
         case (cap_slot_ff)
            SLOT_X_LO: raw_x_in[7:0]  = cap_data;
            SLOT_X_HI: raw_x_in[15:8] = cap_data;
            SLOT_Y_LO: raw_y_in[7:0]  = cap_data;
            SLOT_Y_HI: raw_y_in[15:8] = cap_data;
            SLOT_B1:   btn_hit_in[0]  = |(cap_data & btn_masks_ff[7:0]);
            SLOT_B2:   btn_hit_in[1]  = |(cap_data & btn_masks_ff[15:8]);
            SLOT_B3:   btn_hit_in[2]  = |(cap_data & btn_masks_ff[23:16]);
            SLOT_B4:   btn_hit_in[3]  = |(cap_data & btn_masks_ff[31:24]);
            default:   ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               count_in = count_inc;
               if (req_item.last_byte) begin
                  count_in = '0;
                  if (LEN_W'(count_inc) >= min_len_ff) begin
                     state_in  = S_READ;
                     rd_cnt_in = '0;
                     axis_in   = AXIS_X;
                  end
               end
            end
         end
         S_READ: begin
            if (rd_cnt_ff == READ_DONE) begin
               state_in = S_PREP;
            end else begin
               cap_valid_in = 1'b1;
               cap_slot_in  = rd_cnt_ff[2:0];
               cap_zero_in  = slot_zero;
               rd_cnt_in    = rd_cnt_ff + 1'b1;
            end
         end
         S_PREP: begin
            if (raw_bypass) begin
               axis_store = 1'b1;
               axis_value = raw_clamped;
            end else if (den_zero) begin
               axis_store = 1'b1;
               axis_value = 8'd128;
            end else if (quo_nonpos) begin
               axis_store = 1'b1;
               axis_value = 8'd0;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               axis_store = 1'b1;
               axis_value = quo_clamped;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = new_item;
               prev_map_in  = new_map;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // An axis is finished: keep it and move on to the Y axis or, after Y, to S_EMIT.
      if (axis_store) begin
         if (axis_ff == AXIS_X) begin
            ax_in    = axis_value;
            axis_in  = AXIS_Y;
            state_in = S_PREP;
         end else begin
            ay_in    = axis_value;
            state_in = S_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= AXIS_X;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         cap_valid_ff <= 1'b0;
         prev_map_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         cap_valid_ff <= cap_valid_in;
         prev_map_ff  <= prev_map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cap_slot_ff <= cap_slot_in;
      cap_zero_ff <= cap_zero_in;
      raw_x_ff    <= raw_x_in;
      raw_y_ff    <= raw_y_in;
      btn_hit_ff  <= btn_hit_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ design/hjrd_checker.sv @@
// ----------------------------------------------------------------------------
// HID joystick report decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hjrd_checker import hjrd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   // A result that is held off stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed or vanished while stalled");

   // A byte that does not end a report keeps the block collecting.
   a_mid_report_open: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_item.last_byte |=> !req_stall)
      else $error("input held off in the middle of a report");

   // A new result only follows a decode, never a byte in mid report.
   a_no_rsp_mid_report: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_item.last_byte |=> !$rose(rsp_valid))
      else $error("result appeared after a byte that is not the last");

   // The direction bits follow the analog values they were derived from.
   a_dir_matches_analog: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_item.direction_map[0] == ($signed(rsp_item.analog_x) > 8'sd64)) &&
         (rsp_item.direction_map[1] == ($signed(rsp_item.analog_x) < -8'sd64)) &&
         (rsp_item.direction_map[2] == ($signed(rsp_item.analog_y) > 8'sd64)) &&
         (rsp_item.direction_map[3] == ($signed(rsp_item.analog_y) < -8'sd64)))
      else $error("direction bits disagree with analog values");

endmodule

bind hid_joystick_report_decode hjrd_checker u_hjrd_checker (.*);
